// ===== hw/rtl/hlts_pkg.sv =====
// Shared types and constants for the header/length/tail frame sync unit.
// No dependencies; the controller, datapath, registers and top level import it.
package hlts_pkg;

  // Configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_HEADER_WORD   = 3'd0,
    REG_HEADER_LENGTH = 3'd1,
    REG_FRAME_LENGTH  = 3'd2,
    REG_TAIL_CHECK    = 3'd3,
    REG_TAIL_BYTE     = 3'd4
  } reg_idx_e;

  localparam logic [31:0] HEADER_WORD_RST   = 32'h0000_00FF;
  localparam logic [2:0]  HEADER_LENGTH_RST = 3'd1;
  localparam logic [5:0]  FRAME_LENGTH_RST  = 6'd7;
  localparam logic        TAIL_CHECK_RST    = 1'b0;
  localparam logic [7:0]  TAIL_BYTE_RST     = 8'h0D;

  localparam int unsigned POS_W = 5;

  typedef struct packed {
    logic [31:0] header_word;
    logic [2:0]  hdr_len;
    logic [5:0]  frame_length;
    logic        tail_check;
    logic [7:0]  tail_byte;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;     // rx transfer this cycle
    logic rd_tail;    // read store at frame_length - 1
    logic ld_first;   // start replay at byte 0
    logic load_out;   // capture read data into output register
    logic next_byte;  // advance replay index
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_done; // accepted byte completes a frame
    logic tail_ok;    // tail byte passes (or check off)
    logic last;       // output register holds final byte
  } dp_sts_t;

endpackage

// ===== hw/rtl/hlts_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module hlts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/hlts_regs.sv =====
// APB configuration registers of the frame sync unit.
// Depends on hlts_pkg (register map, reset values, cfg_t).
module hlts_regs
  import hlts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_d, cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER_WORD:   cfg_d.header_word   = pwdata;
        REG_HEADER_LENGTH: cfg_d.hdr_len       = pwdata[2:0];
        REG_FRAME_LENGTH:  cfg_d.frame_length  = pwdata[5:0];
        REG_TAIL_CHECK:    cfg_d.tail_check    = pwdata[0];
        REG_TAIL_BYTE:     cfg_d.tail_byte     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEADER_WORD:   prdata = cfg_q.header_word;
      REG_HEADER_LENGTH: prdata = APB_DW'(cfg_q.hdr_len);
      REG_FRAME_LENGTH:  prdata = APB_DW'(cfg_q.frame_length);
      REG_TAIL_CHECK:    prdata = APB_DW'(cfg_q.tail_check);
      REG_TAIL_BYTE:     prdata = APB_DW'(cfg_q.tail_byte);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_word   <= HEADER_WORD_RST;
      cfg_q.hdr_len       <= HEADER_LENGTH_RST;
      cfg_q.frame_length  <= FRAME_LENGTH_RST;
      cfg_q.tail_check    <= TAIL_CHECK_RST;
      cfg_q.tail_byte     <= TAIL_BYTE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/hlts_dpath.sv =====
// Datapath of the frame sync unit: header match, fill count, frame store,
// tail check and replay output register. Depends on hlts_pkg and hlts_ram.
module hlts_dpath
  import hlts_pkg::*;
#(
  parameter int unsigned MAX_FRAME  = 32,
  parameter int unsigned MAX_HEADER = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             line_error_i,
  output logic [7:0]       frame_byte_o,
  output logic [POS_W-1:0] byte_position_o,
  output logic             last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_FRAME);
  localparam int unsigned LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int unsigned CW     = (LEN_W + 1 > 7) ? LEN_W + 1 : 7;
  localparam int unsigned FILL_W = IDX_W;

  logic              in_frame_d, in_frame_q;
  logic [FILL_W-1:0] fill_d, fill_q;
  logic [LEN_W-1:0]  fl_q;
  logic              tchk_q;
  logic [7:0]        tbyte_q;
  logic [IDX_W-1:0]  k_q;
  logic [7:0]        byte_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;

  logic [2:0]        hl_eff;
  logic [CW-1:0]     hl_w, fl_w, fill_w, pos_w, idx_w, fill_nx, wr_idx;
  logic [7:0]        want;
  logic              hdr_match, hdr_full, done, take;
  logic              we;
  logic [IDX_W-1:0]  raddr, fl_m1;
  logic [7:0]        rdata;

  // Effective lengths, clamped as the registers may hold anything
  always_comb begin
    hl_eff = cfg_i.hdr_len;
    if (hl_eff == 3'd0) hl_eff = 3'd1;
    if (hl_eff > 3'(MAX_HEADER)) hl_eff = 3'(MAX_HEADER);
    hl_w = CW'(hl_eff);
    fl_w = CW'(cfg_i.frame_length);
    if (fl_w <= hl_w) fl_w = hl_w + CW'(1);
    if (fl_w > CW'(MAX_FRAME)) fl_w = CW'(MAX_FRAME);
  end

  assign fill_w    = CW'(fill_q);
  assign pos_w     = (fill_w < hl_w) ? fill_w : '0;
  assign want      = cfg_i.header_word[{pos_w[1:0], 3'b000} +: 8];
  assign hdr_match = (rx_byte_i == want);
  assign hdr_full  = (pos_w + CW'(1) == hl_w);

  assign idx_w     = hl_w + fill_w;
  assign fill_nx   = fill_w + CW'(1);
  assign done      = (fill_nx >= fl_w - hl_w);

  assign take      = cmd_i.accept & ~line_error_i;
  assign wr_idx    = in_frame_q ? idx_w : pos_w;
  assign we        = take & (wr_idx < CW'(MAX_FRAME));

  always_comb begin
    in_frame_d = in_frame_q;
    fill_d     = fill_q;
    if (cmd_i.accept) begin
      if (line_error_i) begin
        in_frame_d = 1'b0;
        fill_d     = '0;
      end else if (!in_frame_q) begin
        if (hdr_match && hdr_full) begin
          in_frame_d = 1'b1;
          fill_d     = '0;
        end else if (hdr_match) begin
          fill_d = FILL_W'(pos_w + CW'(1));
        end else begin
          fill_d = '0;
        end
      end else if (done) begin
        in_frame_d = 1'b0;
        fill_d     = '0;
      end else begin
        fill_d = FILL_W'(fill_nx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      fill_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      fill_q     <= fill_d;
    end
  end

  // Frame parameters are frozen when a frame completes
  always_ff @(posedge clk_i) begin
    if (sts_o.frame_done) begin
      fl_q    <= LEN_W'(fl_w);
      tchk_q  <= cfg_i.tail_check;
      tbyte_q <= cfg_i.tail_byte;
    end
    if (cmd_i.ld_first) begin
      k_q <= '0;
    end else if (cmd_i.next_byte) begin
      k_q <= k_q + IDX_W'(1);
    end
    if (cmd_i.load_out) begin
      byte_q <= rdata;
      pos_q  <= POS_W'(k_q);
      last_q <= (k_q == fl_m1);
    end
  end

  assign fl_m1 = IDX_W'(fl_q - LEN_W'(1));
  assign raddr = cmd_i.rd_tail ? fl_m1 : k_q;

  hlts_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_idx[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.frame_done = take & in_frame_q & done;
  assign sts_o.tail_ok    = ~tchk_q | (rdata == tbyte_q);
  assign sts_o.last       = last_q;

  assign frame_byte_o    = byte_q;
  assign byte_position_o = pos_q;
  assign last_o          = last_q;

endmodule

// ===== hw/rtl/hlts_ctrl.sv =====
// Controller of the frame sync unit: input handshake, tail check and
// replay sequencing. Depends on hlts_pkg (dp_cmd_t, dp_sts_t).
module hlts_ctrl
  import hlts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    rx_valid_i,
  output logic    rx_ready_o,
  output logic    frame_valid_o,
  input  logic    frame_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_TAIL_RD  = 6'b000010,
    S_TAIL_CHK = 6'b000100,
    S_RD       = 6'b001000,
    S_LOAD     = 6'b010000,
    S_SEND     = 6'b100000
  } state_e;

  state_e state_d, state_q;

  assign rx_ready_o    = (state_q == S_IDLE);
  assign frame_valid_o = (state_q == S_SEND);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = rx_valid_i;
        if (rx_valid_i && sts_i.frame_done) state_d = S_TAIL_RD;
      end
      S_TAIL_RD: begin
        cmd_o.rd_tail = 1'b1;
        state_d       = S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (sts_i.tail_ok) begin
          cmd_o.ld_first = 1'b1;
          state_d        = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_SEND;
      end
      S_SEND: begin
        if (frame_ready_i) begin
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_byte = 1'b1;
            state_d         = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/header_length_tail_frame_sync_unit.sv =====
// Frame synchronizer for one serial receive channel: hunts for a 1..4 byte
// header, collects a fixed-length frame, optionally checks the tail byte and
// replays a good frame byte by byte.
//
// Channels: rx (rx_byte_i, line_error_i) and frame (frame_byte_o,
// byte_position_o, last_o), both valid/ready; a transfer happens when both
// are high. line_error_i set in a transfer drops the partial frame and sends
// the parser back to hunting. Configuration through the APB port, one
// 32-bit register every 4 bytes.
// Sequencing: a byte that does not end a frame leaves rx ready. The byte
// that ends a frame starts a tail read of the frame store (S_TAIL_RD,
// S_TAIL_CHK); if the tail passes, each frame byte then goes through store
// read, output load and transfer (S_RD, S_LOAD, S_SEND), the transfer
// waiting while the receiver holds frame_ready_i low. rx is held off until
// the unit is idle again, a sequence set by the store's single read port.
// Reset: registers return to header 0xFF, header length 1, frame length 7,
// tail check off, tail 0x0D; the parser starts hunting. The frame store is
// not cleared. A stalled output byte simply holds in the output register.
module header_length_tail_frame_sync_unit
  import hlts_pkg::*;
#(
  parameter int unsigned MAX_FRAME  = 32,
  parameter int unsigned MAX_HEADER = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // receive bytes
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              line_error_i,
  // replayed frame
  output logic              frame_valid_o,
  input  logic              frame_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic [POS_W-1:0]  byte_position_o,
  output logic              last_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  hlts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hlts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .frame_valid_o (frame_valid_o),
    .frame_ready_i (frame_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  hlts_dpath #(
    .MAX_FRAME  (MAX_FRAME),
    .MAX_HEADER (MAX_HEADER)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_byte_i),
    .line_error_i    (line_error_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_o          (last_o)
  );

endmodule
